// ----- src/lccd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lccd_pkg;

	localparam int TABLE_DEPTH     = 16;
	localparam int MAX_ENTRIES_DEF = 16;

	localparam int VAL_W  = 16;
	localparam int STK_W  = 8;
	localparam int AMT_W  = 24;
	localparam int PROD_W = VAL_W + STK_W;
	localparam int SUM_W  = PROD_W + $clog2(TABLE_DEPTH);

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 56;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_DISP  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [STK_W-1:0] stock;
	} entry_t;

	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] den;
		logic [STK_W-1:0] stock;
		logic [AMT_W-1:0] amount;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [STK_W-1:0] give;
		logic [AMT_W-1:0] gv;
	} div_rsp_t;

endpackage

`default_nettype wire

// ----- src/lccd_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lccd_table import lccd_pkg::*; #(
	parameter int DEPTH = MAX_ENTRIES_DEF,
	parameter int IDX_W = 4
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire entry_t           wdata,
	input  wire logic             re,
	input  wire logic [IDX_W-1:0] raddr,
	output entry_t                rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- src/lccd_quot.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Largest coin count g <= stock with g * den <= amount (zero if den is zero), one bit per cycle.
module lccd_quot import lccd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int BIT_W = $clog2(STK_W);

	logic             busy_q;
	logic             done_q;
	logic [BIT_W-1:0] bit_q;
	logic [STK_W-1:0] g_q;
	logic [AMT_W-1:0] gv_q;
	logic [VAL_W-1:0] den_q;
	logic [STK_W-1:0] stk_q;
	logic [AMT_W-1:0] amt_q;

	logic [STK_W-1:0] trial_g;
	logic [AMT_W:0]   trial_gv;
	logic             take;

	assign trial_g  = g_q | (STK_W'(1) << bit_q);
	assign trial_gv = {1'b0, gv_q} + ((AMT_W + 1)'(den_q) << bit_q);
	assign take     = (den_q != '0) && (trial_g <= stk_q) && (trial_gv <= {1'b0, amt_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				bit_q  <= BIT_W'(STK_W - 1);
			end else if (busy_q) begin
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			g_q   <= '0;
			gv_q  <= '0;
			den_q <= req.den;
			stk_q <= req.stock;
			amt_q <= req.amount;
		end else if (busy_q && take) begin
			g_q  <= trial_g;
			gv_q <= trial_gv[AMT_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.give = g_q;
	assign rsp.gv   = gv_q;

endmodule

`default_nettype wire

// ----- src/limited_coin_change_dispenser_top.sv -----
// Channel  | Dir | Handshake                   | Payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready | tuser: operation; tdata: value, stock, amount
// m_axis   | out | m_axis_tvalid/m_axis_tready | tuser: refused; tlast: last; tdata: result
//
// The block works on one word at a time. A clear only resets the entry count. A load
// compares entries on the way down: each entry below the new one is shifted up,
// and the first entry not below it ends the search.
// A dispense over N entries first reads each entry and sums value times stock;
// if the sum covers the amount it then does, per entry, one table read, eight
// steps of the bit-serial coin-count unit, write-back and emit.
// Reset clears the entry count, the sequencer and the output valid; table contents
// are not cleared and only entries below the count are ever read.
// The input is taken whenever the sequencer is idle, even while a result waits on
// m_axis; a stalled m_axis holds the sequencer in its emit step.
`timescale 1ns / 1ps
`default_nettype none

module limited_coin_change_dispenser_top import lccd_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// [15:0] coin_value, [23:16] coin_stock, [47:24] change_amount
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] operation
	input  wire logic [1:0]            s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// [15:0] slot_value, [23:16] coins_given, [31:24] coins_remaining, [55:32] leftover
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	// [0] refused
	output logic                       m_axis_tuser,
	output logic                       m_axis_tlast
);

	// Capacity is the smaller of the parameter and the table depth.
	localparam int CAP   = (MAX_ENTRIES < TABLE_DEPTH) ? MAX_ENTRIES : TABLE_DEPTH;
	localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
	localparam int CNT_W = $clog2(CAP + 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_LD_RD  = 4'd1;
	localparam logic [3:0] ST_LD_CMP = 4'd2;
	localparam logic [3:0] ST_LD_PUT = 4'd3;
	localparam logic [3:0] ST_SM_RD  = 4'd4;
	localparam logic [3:0] ST_SM_MUL = 4'd5;
	localparam logic [3:0] ST_SM_ACC = 4'd6;
	localparam logic [3:0] ST_SM_CHK = 4'd7;
	localparam logic [3:0] ST_DS_RD  = 4'd8;
	localparam logic [3:0] ST_DS_LD  = 4'd9;
	localparam logic [3:0] ST_DS_DIV = 4'd10;
	localparam logic [3:0] ST_EMIT   = 4'd11;

	typedef struct packed {
		logic             last;
		logic             refused;
		logic [AMT_W-1:0] leftover;
		logic [STK_W-1:0] remain;
		logic [STK_W-1:0] given;
		logic [VAL_W-1:0] slot;
	} res_t;

	logic [3:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic             m_valid_q;

	logic [VAL_W-1:0]  val_q;
	logic [STK_W-1:0]  stk_q;
	logic [AMT_W-1:0]  amt_q;
	logic [SUM_W-1:0]  total_q;
	logic [PROD_W-1:0] prod_s1;
	logic [VAL_W-1:0]  cur_val_q;
	logic [STK_W-1:0]  cur_stk_q;
	res_t              res_q;
	res_t              out_q;

	logic             in_acc;
	logic             out_free;
	logic             emit_go;
	logic [CNT_W-1:0] idx_m1;
	logic [CNT_W-1:0] idx_p1;
	logic             total_lt;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	entry_t           rd_data;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign emit_go       = (state_q == ST_EMIT) && out_free;
	assign idx_m1        = idx_q - 1'b1;
	assign idx_p1        = idx_q + 1'b1;
	assign total_lt      = total_q < SUM_W'(amt_q);

	// Table port steering. The sequencer never reads and writes one entry in the
	// same cycle, so no forwarding path is needed.
	always_comb begin
		mem_re    = (state_q == ST_LD_RD) || (state_q == ST_SM_RD) || (state_q == ST_DS_RD);
		mem_raddr = (state_q == ST_LD_RD) ? idx_m1[IDX_W-1:0] : idx_q[IDX_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = idx_q[IDX_W-1:0];
		mem_wdata = rd_data;
		if ((state_q == ST_LD_CMP) && (rd_data.value < val_q)) begin
			// shift the smaller entry up one slot
			mem_we = 1'b1;
		end else if (state_q == ST_LD_PUT) begin
			mem_we          = 1'b1;
			mem_wdata.value = val_q;
			mem_wdata.stock = stk_q;
		end else if ((state_q == ST_DS_DIV) && div_rsp.done) begin
			// write back the reduced stock
			mem_we          = 1'b1;
			mem_wdata.value = cur_val_q;
			mem_wdata.stock = cur_stk_q - div_rsp.give;
		end
	end

	assign div_req.start  = (state_q == ST_DS_LD);
	assign div_req.den    = rd_data.value;
	assign div_req.stock  = rd_data.stock;
	assign div_req.amount = amt_q;

	lccd_table #(
		.DEPTH (CAP),
		.IDX_W (IDX_W)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	lccd_quot u_quot (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// load a new result word, or drop the one taken this cycle
			if (emit_go) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (s_axis_tuser)
							OP_LOAD: begin
								// drop a load into a full table
								if (count_q < CNT_W'(CAP)) begin
									idx_q   <= count_q;
									state_q <= (count_q == '0) ? ST_LD_PUT : ST_LD_RD;
								end
							end
							OP_DISP: begin
								idx_q   <= '0;
								state_q <= (count_q == '0) ? ST_SM_CHK : ST_SM_RD;
							end
							OP_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_LD_RD: begin
					state_q <= ST_LD_CMP;
				end
				ST_LD_CMP: begin
					// stop at the first entry not below the new one: equal ones stay ahead
					if (rd_data.value < val_q) begin
						idx_q   <= idx_m1;
						state_q <= (idx_q == CNT_W'(1)) ? ST_LD_PUT : ST_LD_RD;
					end else begin
						state_q <= ST_LD_PUT;
					end
				end
				ST_LD_PUT: begin
					count_q <= count_q + 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SM_RD: begin
					state_q <= ST_SM_MUL;
				end
				ST_SM_MUL: begin
					state_q <= ST_SM_ACC;
				end
				ST_SM_ACC: begin
					if (idx_p1 == count_q) begin
						state_q <= ST_SM_CHK;
					end else begin
						idx_q   <= idx_p1;
						state_q <= ST_SM_RD;
					end
				end
				ST_SM_CHK: begin
					idx_q   <= '0;
					state_q <= (total_lt || (count_q == '0)) ? ST_EMIT : ST_DS_RD;
				end
				ST_DS_RD: begin
					state_q <= ST_DS_LD;
				end
				ST_DS_LD: begin
					state_q <= ST_DS_DIV;
				end
				ST_DS_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// hold here until the output register frees up
					if (out_free) begin
						if (res_q.last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_p1;
							state_q <= ST_DS_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			val_q   <= s_axis_tdata[15:0];
			stk_q   <= s_axis_tdata[23:16];
			amt_q   <= s_axis_tdata[47:24];
			total_q <= '0;
		end
		if (state_q == ST_SM_MUL) begin
			prod_s1 <= PROD_W'(rd_data.value) * PROD_W'(rd_data.stock);
		end
		if (state_q == ST_SM_ACC) begin
			total_q <= total_q + SUM_W'(prod_s1);
		end
		if (state_q == ST_SM_CHK) begin
			// refused, or an empty table asked for nothing
			res_q.slot     <= '0;
			res_q.given    <= '0;
			res_q.remain   <= '0;
			res_q.refused  <= total_lt;
			res_q.leftover <= amt_q;
			res_q.last     <= 1'b1;
		end
		if (state_q == ST_DS_LD) begin
			cur_val_q <= rd_data.value;
			cur_stk_q <= rd_data.stock;
		end
		if ((state_q == ST_DS_DIV) && div_rsp.done) begin
			amt_q          <= amt_q - div_rsp.gv;
			res_q.slot     <= cur_val_q;
			res_q.given    <= div_rsp.give;
			res_q.remain   <= cur_stk_q - div_rsp.give;
			res_q.refused  <= 1'b0;
			res_q.leftover <= amt_q - div_rsp.gv;
			res_q.last     <= (idx_p1 == count_q);
		end
		if ((state_q == ST_EMIT) && out_free) begin
			out_q <= res_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {out_q.leftover, out_q.remain, out_q.given, out_q.slot};
	assign m_axis_tuser  = out_q.refused;
	assign m_axis_tlast  = out_q.last;

endmodule

`default_nettype wire

// ----- src/lccd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lccd_checker import lccd_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic                  m_axis_tuser,
	input wire logic                  m_axis_tlast
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result word changed while stalled");

	// a refusal is the only word of its dispense
	a_refused_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("refused word without last");

	// a refusal reports no slot and no coins
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:0] == 32'd0)
		else $error("refused word carries coins");

	// a zero denomination never gives coins
	a_zero_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[15:0] == 16'd0 |-> m_axis_tdata[23:16] == 8'd0)
		else $error("coins given from a zero denomination");

endmodule

bind limited_coin_change_dispenser_top lccd_checker u_lccd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- bench/tb_limited_coin_change_dispenser_top.sv -----
`timescale 1ns / 1ps

// Checks the coin change dispenser against its own inventory predictor.
// Words go in on s_axis: loads, dispenses, clears and the unused operation.
// Every accepted word updates a private copy of the coin table here, and each
// dispense queues the results it must produce. Each result word on m_axis is
// compared field by field with the oldest queued one.
// Both sides pause at random. One phase holds m_axis off long enough for the
// block to stall its input.
module tb_limited_coin_change_dispenser_top;
	import lccd_pkg::*;

	localparam int CAPACITY       = (MAX_ENTRIES_DEF < TABLE_DEPTH) ? MAX_ENTRIES_DEF : TABLE_DEPTH;
	localparam int RANDOM_WORDS   = 175;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 400;
	localparam int HOLD_CYCLES    = 400;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [AMT_W-1:0] AMT_MAX = {AMT_W{1'b1}};

	// One result word of a dispense, as the block should report it
	typedef struct packed {
		logic [VAL_W-1:0] slot_value;
		logic [STK_W-1:0] coins_given;
		logic [STK_W-1:0] coins_remaining;
		logic             refused;
		logic [AMT_W-1:0] leftover;
		logic             last;
	} coin_result_t;

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  s_axis_tvalid  = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata   = '0;
	logic [1:0]            s_axis_tuser   = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;

	// Private copy of the coin table, kept in descending denomination order
	logic [VAL_W-1:0] inventory_value [TABLE_DEPTH];
	logic [STK_W-1:0] inventory_stock [TABLE_DEPTH];
	int unsigned      inventory_count = 0;

	coin_result_t change_due_q[$];

	int unsigned error_count   = 0;
	int unsigned words_sent    = 0;
	int unsigned hold_request  = 0;
	bit          src_idle      = 1'b1;
	bit          snk_idle      = 1'b1;

	limited_coin_change_dispenser_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void push_result(input logic [VAL_W-1:0] slot, input logic [STK_W-1:0] given,
			input logic [STK_W-1:0] remain, input logic refused, input logic [AMT_W-1:0] left,
			input logic last);
		coin_result_t r;
		r.slot_value      = slot;
		r.coins_given     = given;
		r.coins_remaining = remain;
		r.refused         = refused;
		r.leftover        = left;
		r.last            = last;
		change_due_q.push_back(r);
	endfunction

	// Total value held in the table, in cents
	function automatic longint unsigned stored_value();
		longint unsigned total;
		total = 0;
		for (int i = 0; i < inventory_count; i++)
			total += longint'(inventory_value[i]) * longint'(inventory_stock[i]);
		return total;
	endfunction

	// Apply one accepted word to the table copy and queue what it must produce.
	// Return 0 for words the block simply drops (unused code, load into a full table).
	function automatic bit predict_coin_word(input logic [1:0] op, input logic [VAL_W-1:0] val,
			input logic [STK_W-1:0] stk, input logic [AMT_W-1:0] amt);
		int unsigned pos;
		int unsigned left;
		int unsigned give;
		int unsigned quot;
		case (op)
			OP_LOAD: begin
				if (inventory_count >= CAPACITY)
					return 1'b0;
				// Equal denominations: the new entry lands after the existing ones
				pos = 0;
				while (pos < inventory_count && inventory_value[pos] >= val)
					pos++;
				for (int i = inventory_count; i > pos; i--) begin
					inventory_value[i] = inventory_value[i-1];
					inventory_stock[i] = inventory_stock[i-1];
				end
				inventory_value[pos] = val;
				inventory_stock[pos] = stk;
				inventory_count++;
				return 1'b1;
			end
			OP_DISP: begin
				if (stored_value() < longint'(amt)) begin
					push_result('0, '0, '0, 1'b1, amt, 1'b1);
				end else if (inventory_count == 0) begin
					push_result('0, '0, '0, 1'b0, amt, 1'b1);
				end else begin
					left = amt;
					for (int i = 0; i < inventory_count; i++) begin
						give = 0;
						// A zero denomination hands out nothing and leaves the amount alone
						if (inventory_value[i] != 0) begin
							quot = left / inventory_value[i];
							give = (quot < inventory_stock[i]) ? quot : inventory_stock[i];
							left -= give * inventory_value[i];
							inventory_stock[i] = inventory_stock[i] - STK_W'(give);
						end
						push_result(inventory_value[i], STK_W'(give), inventory_stock[i], 1'b0,
							AMT_W'(left), i + 1 == inventory_count);
					end
				end
				return 1'b1;
			end
			OP_CLEAR: begin
				inventory_count = 0;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// ---------------------------------------------------------------- input side

	// Offer one word, after a random pause while src_idle is set, and hold it until accepted. Leave
	// tvalid high on return so back-to-back words need no extra edge.
	task automatic send_coin_word(input logic [1:0] op, input logic [VAL_W-1:0] val,
			input logic [STK_W-1:0] stk, input logic [AMT_W-1:0] amt);
		int unsigned gap;
		gap = src_idle ? $urandom_range(0, 19) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tuser  <= op;
		s_axis_tdata  <= {amt, stk, val};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if (predict_coin_word(op, val, stk, amt))
			words_sent++;
	endtask

	// ---------------------------------------------------------------- output side

	// Pause before each result word; a pending hold request drops tready for
	// a long stretch, counted here, so the block backs up into its input.
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_request != 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_request) @(posedge clk);
				hold_request = 0;
			end else begin
				automatic int unsigned gap = snk_idle ? $urandom_range(0, 19) : 0;
				if (gap != 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				m_axis_tready <= 1'b1;
				@(posedge clk);
				while (!m_axis_tvalid && hold_request == 0) @(posedge clk);
			end
		end
	end

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
			error_count++;
		end
	endfunction

	// Compare every accepted result word with the oldest queued expectation
	always @(posedge clk) begin : check_results
		coin_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (change_due_q.size() == 0) begin
				$display("%0t: unexpected result: expected none actual tdata %h tuser %b tlast %b",
					$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
				error_count++;
			end else begin
				want = change_due_q.pop_front();
				compare_field("slot_value",      want.slot_value,      m_axis_tdata[15:0]);
				compare_field("coins_given",     want.coins_given,     m_axis_tdata[23:16]);
				compare_field("coins_remaining", want.coins_remaining, m_axis_tdata[31:24]);
				compare_field("leftover",        want.leftover,        m_axis_tdata[55:32]);
				compare_field("refused",         want.refused,         m_axis_tuser);
				compare_field("last",            want.last,            m_axis_tlast);
			end
		end
	end

	// Count cycles in which work is pending but no word moves on either side
	initial begin : watchdog
		int unsigned stuck;
		stuck = 0;
		while (stuck < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stuck = 0;
			else if (s_axis_tvalid || change_due_q.size() != 0)
				stuck++;
			else
				stuck = 0;
		end
		$display("tb_limited_coin_change_dispenser_top: errors");
		$finish;
	end

	// ---------------------------------------------------------------- stimulus helpers

	function automatic logic [VAL_W-1:0] pick_denomination();
		case ($urandom_range(0, 19))
			0:       return '0;
			1, 2, 3: return VAL_W'($urandom_range(1, 65535));
			4:       return 16'd1;
			5:       return 16'd2;
			6:       return 16'd5;
			7:       return 16'd10;
			8, 9:    return 16'd25;
			10:      return 16'd50;
			11:      return 16'd100;
			12:      return 16'd200;
			13:      return 16'd500;
			14:      return 16'd1000;
			15:      return 16'd2000;
			default: return VAL_W'($urandom_range(1, 300));
		endcase
	endfunction

	function automatic logic [STK_W-1:0] pick_stock();
		return STK_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
			: $urandom_range(0, 25));
	endfunction

	// Mostly amounts the table can cover, plus the exact total, just past it,
	// zero and anything at all
	function automatic logic [AMT_W-1:0] pick_amount();
		longint unsigned total;
		logic [AMT_W-1:0] cap;
		total = stored_value();
		cap = (total > longint'(AMT_MAX)) ? AMT_MAX : total[AMT_W-1:0];
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return AMT_W'($urandom_range(0, AMT_MAX));
			2:       return cap;
			3:       return cap + 1'b1;
			default: return AMT_W'($urandom_range(0, cap));
		endcase
	endfunction

	// ---------------------------------------------------------------- tests

	// Empty table: zero amount passes with one empty result, anything else is refused
	task automatic test_empty_table();
		send_coin_word(OP_DISP, '0, '0, '0);
		send_coin_word(OP_DISP, '1, '1, 24'd1);
		send_coin_word(OP_CLEAR, '1, '1, '1);
		send_coin_word(OP_DISP, '0, '0, AMT_MAX);
	endtask

	// Field extremes, equal and zero denominations, a full table, refusal,
	// an exact payout and the unused operation code
	task automatic test_directed_table();
		send_coin_word(OP_CLEAR, '0, '0, '0);
		send_coin_word(OP_LOAD, 16'hFFFF, 8'hFF, '0);
		send_coin_word(OP_LOAD, 16'd25, 8'd10, AMT_MAX);
		send_coin_word(OP_LOAD, 16'd0, 8'd7, '0);
		send_coin_word(OP_LOAD, 16'd25, 8'd3, '0);
		send_coin_word(OP_LOAD, 16'd1, 8'hFF, '0);
		send_coin_word(OP_LOAD, 16'd7, 8'd0, '0);
		for (int k = 1; k <= 10; k++)
			send_coin_word(OP_LOAD, 16'(100 * k), 8'd1, '0);
		// Table is full now: drop this one
		send_coin_word(OP_LOAD, 16'd500, 8'd9, '0);
		send_coin_word(OP_DISP, '0, '0, AMT_MAX);
		send_coin_word(OP_DISP, '0, '0, 24'd65586);
		send_coin_word(OP_DISP, '0, '0, AMT_W'(stored_value()));
		send_coin_word(OP_DISP, '0, '0, 24'd1);
		send_coin_word(OP_UNUSED, '1, '1, '1);
	endtask

	// Stall m_axis for a long stretch while dispenses keep arriving back to back
	task automatic test_output_backpressure();
		src_idle = 1'b0;
		send_coin_word(OP_CLEAR, '0, '0, '0);
		send_coin_word(OP_LOAD, 16'd100, 8'd20, '0);
		send_coin_word(OP_LOAD, 16'd10, 8'd20, '0);
		send_coin_word(OP_LOAD, 16'd1, 8'd20, '0);
		hold_request = HOLD_CYCLES;
		repeat (6)
			send_coin_word(OP_DISP, VAL_W'($urandom), STK_W'($urandom),
				AMT_W'($urandom_range(0, 2000)));
		src_idle = 1'b1;
	endtask

	// Mostly well-formed refill-and-pay sequences with random content, the
	// rest noise words and sequences on a stale table
	task automatic test_random_sequences();
		int unsigned first;
		int unsigned n_loads;
		first = words_sent;
		while (words_sent - first < RANDOM_WORDS) begin
			src_idle = ($urandom_range(0, 3) != 0);
			snk_idle = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, 4))
					send_coin_word(2'($urandom_range(0, 3)), VAL_W'($urandom),
						STK_W'($urandom), AMT_W'($urandom));
			end else begin
				if ($urandom_range(0, 3) != 0)
					send_coin_word(OP_CLEAR, VAL_W'($urandom), STK_W'($urandom),
						AMT_W'($urandom));
				// Keep most tables small; now and then overfill one
				n_loads = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
				repeat (n_loads)
					send_coin_word(OP_LOAD, pick_denomination(), pick_stock(), AMT_W'($urandom));
				repeat ($urandom_range(1, 4))
					send_coin_word(OP_DISP, VAL_W'($urandom), STK_W'($urandom), pick_amount());
			end
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_directed_table();
		test_output_backpressure();
		test_random_sequences();

		// Drop valid, drain the results, then give trailing loads time to finish
		// and any stray word time to show up
		s_axis_tvalid <= 1'b0;
		while (change_due_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("tb_limited_coin_change_dispenser_top: clean");
		else
			$display("tb_limited_coin_change_dispenser_top: errors");
		$finish;
	end

endmodule

// ----- limited_coin_change_dispenser_top.f -----
src/lccd_pkg.sv
src/lccd_table.sv
src/lccd_quot.sv
src/limited_coin_change_dispenser_top.sv
src/lccd_checker.sv
bench/tb_limited_coin_change_dispenser_top.sv
